// ----- hdl/scheme_number_literal_lexer_defines.svh -----
// assertion macros used by the checker file
`ifndef SCHEME_NUMBER_LITERAL_LEXER_DEFINES_SVH
`define SCHEME_NUMBER_LITERAL_LEXER_DEFINES_SVH

// same-cycle implication, held off while reset is asserted
`define SNL_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("snl assertion failed");

// next-cycle implication, held off while reset is asserted
`define SNL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("snl assertion failed");

`endif

// ----- hdl/snl_pkg.sv -----
// types, codes and constants for the number literal lexer
package snl_pkg;

    localparam int unsigned MAX_TOKEN_LEN = 255;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_INVALID = 2'd1;
    localparam logic [1:0] STATUS_DECODE  = 2'd2;

    localparam logic [1:0] RADIX_BIN = 2'd0;
    localparam logic [1:0] RADIX_OCT = 2'd1;
    localparam logic [1:0] RADIX_DEC = 2'd2;
    localparam logic [1:0] RADIX_HEX = 2'd3;

    localparam logic [1:0] EXACT_NONE    = 2'd0;
    localparam logic [1:0] EXACT_EXACT   = 2'd1;
    localparam logic [1:0] EXACT_INEXACT = 2'd2;

    localparam logic [1:0] FORM_REAL  = 2'd0;
    localparam logic [1:0] FORM_RECT  = 2'd1;
    localparam logic [1:0] FORM_POLAR = 2'd2;

    localparam logic [2:0] K_NONE   = 3'd0;
    localparam logic [2:0] K_INT    = 3'd1;
    localparam logic [2:0] K_DEC    = 3'd2;
    localparam logic [2:0] K_RATIO  = 3'd3;
    localparam logic [2:0] K_INF    = 3'd4;
    localparam logic [2:0] K_NAN    = 3'd5;
    localparam logic [2:0] K_BARE_I = 3'd6;

    localparam logic [1:0] SIGN_NONE  = 2'd0;
    localparam logic [1:0] SIGN_PLUS  = 2'd1;
    localparam logic [1:0] SIGN_MINUS = 2'd2;

    localparam logic [1:0] EXP_NONE = 2'd0;
    localparam logic [1:0] EXP_POS  = 2'd1;
    localparam logic [1:0] EXP_NEG  = 2'd2;

    typedef struct packed {
        logic [7:0] character;
        logic       end_of_input;
        logic       bad_sequence;
    } t_in;

    typedef struct packed {
        logic [1:0] status;
        logic [1:0] radix_code;
        logic [1:0] exactness;
        logic [1:0] form;
        logic [2:0] first_kind;
        logic [1:0] first_sign;
        logic [1:0] first_exponent;
        logic [2:0] second_kind;
        logic [1:0] second_sign;
        logic [1:0] second_exponent;
        logic [7:0] token_length;
    } t_out;

    typedef struct packed {
        logic [2:0] kind;
        logic [1:0] sign;
        logic [1:0] expo;
    } t_part;

    // remaining letters of "inf.0" after "i" and of "nan.0" after "n"
    function automatic logic [7:0] word_char(input logic is_inf, input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = is_inf ? "n" : "a";
            2'd1:    c = is_inf ? "f" : "n";
            2'd2:    c = ".";
            default: c = "0";
        endcase
        return c;
    endfunction

endpackage

// ----- hdl/scheme_number_literal_lexer.sv -----
// Scheme number literal lexer: one character per beat, one descriptor per literal.
// Takes one character beat per clock, back to back, while o_in_ready is high; the parse
// state advances in the same cycle the beat is taken, and the descriptor from the beat that
// ends the literal (a delimiter, end of input, an offending character, the length limit or
// a decode error) is registered into the result register, or into the skid register.
// A two-entry output (result register plus skid register) keeps o_in_ready high while
// one finished result waits; o_in_ready drops only when both entries are occupied.
// After every result the parse state returns to its reset values for the next literal.
module scheme_number_literal_lexer
    import snl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    localparam logic [3:0] PH_PREFIX     = 4'd0;
    localparam logic [3:0] PH_HASH       = 4'd1;
    localparam logic [3:0] PH_PART_BEGIN = 4'd2;
    localparam logic [3:0] PH_AFTER_SIGN = 4'd3;
    localparam logic [3:0] PH_I          = 4'd4;
    localparam logic [3:0] PH_WORD       = 4'd5;
    localparam logic [3:0] PH_INT        = 4'd6;
    localparam logic [3:0] PH_POINT_LEAD = 4'd7;
    localparam logic [3:0] PH_FRAC       = 4'd8;
    localparam logic [3:0] PH_EXP_START  = 4'd9;
    localparam logic [3:0] PH_EXP_SIGNED = 4'd10;
    localparam logic [3:0] PH_EXP_DIG    = 4'd11;
    localparam logic [3:0] PH_DEN0       = 4'd12;
    localparam logic [3:0] PH_DEN        = 4'd13;
    localparam logic [3:0] PH_WORD_DONE  = 4'd14;
    localparam logic [3:0] PH_TAIL       = 4'd15;

    logic [3:0] r_phase, n_phase;
    logic [1:0] r_radix, n_radix;
    logic [1:0] r_flags, n_flags;
    logic [1:0] r_exact, n_exact;
    logic [1:0] r_form, n_form;
    t_part      r_first, n_first;
    t_part      r_second, n_second;
    logic [2:0] r_digits, n_digits;
    logic [7:0] r_token_count, n_token_count;

    logic       r_out_valid;
    t_out       r_out;
    logic       r_skid_valid;
    t_out       r_skid;

    logic [7:0] ch, lo;
    logic       chv;
    logic       is_del, is_dig, is_rdig, is_plus, is_minus, is_sign;
    logic [1:0] sign_code;

    t_part      cur, n_cur;
    logic       v_go, v_bad, v_after, v_move, v_sign2;
    logic       res_valid;
    t_out       res;
    logic       accept, take;

    assign accept     = i_in_valid && o_in_ready;
    assign take       = r_out_valid && i_out_ready;
    assign o_in_ready = !r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // character classes; end of input matches only the delimiter class
    always_comb begin
        ch  = i_in_data.character;
        chv = !i_in_data.end_of_input;
        lo  = (ch inside {["A":"Z"]}) ? ch + 8'h20 : ch;
        is_del = !chv || (ch inside {8'h20, 8'h09, 8'h0D, 8'h0A, "|", "(", ")", "[", "]",
                                     8'h22, ";"});
        is_dig = chv && (ch inside {["0":"9"]});
        case (r_radix)
            RADIX_BIN: is_rdig = chv && (ch inside {["0":"1"]});
            RADIX_OCT: is_rdig = chv && (ch inside {["0":"7"]});
            RADIX_DEC: is_rdig = is_dig;
            default:   is_rdig = is_dig || (chv && (lo inside {["a":"f"]}));
        endcase
        is_plus   = chv && (ch == "+");
        is_minus  = chv && (ch == "-");
        is_sign   = is_plus || is_minus;
        sign_code = is_plus ? SIGN_PLUS : SIGN_MINUS;
    end

    always_comb begin
        n_phase       = r_phase;
        n_radix       = r_radix;
        n_flags       = r_flags;
        n_exact       = r_exact;
        n_form        = r_form;
        n_digits      = r_digits;
        n_token_count = r_token_count;
        cur           = (r_form != FORM_REAL) ? r_second : r_first;
        n_cur         = cur;
        v_go          = 1'b0;
        v_bad         = 1'b0;
        v_after       = 1'b0;
        v_move        = 1'b0;
        v_sign2       = 1'b0;

        case (r_phase)
            PH_PREFIX, PH_PART_BEGIN: begin
                if (r_phase == PH_PREFIX && chv && ch == "#") begin
                    if (r_flags == 2'b11) begin
                        v_bad = 1'b1;
                    end else begin
                        n_phase = PH_HASH;
                        v_go    = 1'b1;
                    end
                end else if (is_sign) begin
                    n_cur.sign = sign_code;
                    n_phase    = PH_AFTER_SIGN;
                    v_go       = 1'b1;
                end else if (r_radix == RADIX_DEC && chv && ch == ".") begin
                    n_cur.kind = K_DEC;
                    n_phase    = PH_POINT_LEAD;
                    v_go       = 1'b1;
                end else if (is_rdig) begin
                    n_cur.kind = K_INT;
                    n_phase    = PH_INT;
                    v_go       = 1'b1;
                end else begin
                    v_bad = 1'b1;
                end
            end
            PH_HASH: begin
                if (!r_flags[0] && chv && (lo inside {"b", "o", "d", "x"})) begin
                    case (lo)
                        "b":     n_radix = RADIX_BIN;
                        "o":     n_radix = RADIX_OCT;
                        "d":     n_radix = RADIX_DEC;
                        default: n_radix = RADIX_HEX;
                    endcase
                    n_flags[0] = 1'b1;
                    n_phase    = PH_PREFIX;
                    v_go       = 1'b1;
                end else if (!r_flags[1] && chv && (lo inside {"e", "i"})) begin
                    n_exact    = (lo == "e") ? EXACT_EXACT : EXACT_INEXACT;
                    n_flags[1] = 1'b1;
                    n_phase    = PH_PREFIX;
                    v_go       = 1'b1;
                end else begin
                    v_bad = 1'b1;
                end
            end
            PH_AFTER_SIGN: begin
                if (chv && lo == "i") begin
                    n_phase = PH_I;
                    v_go    = 1'b1;
                end else if (chv && lo == "n") begin
                    n_cur.kind = K_NAN;
                    n_digits   = 3'd0;
                    n_phase    = PH_WORD;
                    v_go       = 1'b1;
                end else if (r_radix == RADIX_DEC && chv && ch == ".") begin
                    n_cur.kind = K_DEC;
                    n_phase    = PH_POINT_LEAD;
                    v_go       = 1'b1;
                end else if (is_rdig) begin
                    n_cur.kind = K_INT;
                    n_phase    = PH_INT;
                    v_go       = 1'b1;
                end else begin
                    v_bad = 1'b1;
                end
            end
            PH_I: begin
                if (is_del) begin
                    n_cur.kind = K_BARE_I;
                    v_after    = 1'b1;
                end else if (lo == "n") begin
                    n_cur.kind = K_INF;
                    n_digits   = 3'd1;
                    n_phase    = PH_WORD;
                    v_go       = 1'b1;
                end else begin
                    v_bad = 1'b1;
                end
            end
            PH_WORD: begin
                if (!chv || lo != word_char(cur.kind == K_INF, r_digits[1:0])) begin
                    v_bad = 1'b1;
                end else begin
                    n_digits = r_digits + 3'd1;
                    if (r_digits >= 3'd3) begin
                        n_phase = PH_WORD_DONE;
                    end
                    v_go = 1'b1;
                end
            end
            PH_WORD_DONE: begin
                v_after = 1'b1;
            end
            PH_INT: begin
                if (is_rdig) begin
                    v_go = 1'b1;
                end else if (r_radix == RADIX_DEC && chv && ch == ".") begin
                    n_cur.kind = K_DEC;
                    n_phase    = PH_FRAC;
                    v_go       = 1'b1;
                end else if (r_radix == RADIX_DEC && chv && ch == "e") begin
                    n_cur.expo = EXP_POS;
                    n_phase    = PH_EXP_START;
                    v_go       = 1'b1;
                end else if (chv && ch == "/") begin
                    n_cur.kind = K_RATIO;
                    n_phase    = PH_DEN0;
                    v_go       = 1'b1;
                end else begin
                    v_after = 1'b1;
                end
            end
            PH_POINT_LEAD: begin
                if (is_dig) begin
                    n_phase = PH_FRAC;
                    v_go    = 1'b1;
                end else begin
                    v_bad = 1'b1;
                end
            end
            PH_FRAC: begin
                if (is_dig) begin
                    v_go = 1'b1;
                end else if (chv && ch == "e") begin
                    n_cur.expo = EXP_POS;
                    n_phase    = PH_EXP_START;
                    v_go       = 1'b1;
                end else begin
                    v_after = 1'b1;
                end
            end
            PH_EXP_START: begin
                if (is_sign) begin
                    if (is_minus) begin
                        n_cur.expo = EXP_NEG;
                    end
                    n_phase = PH_EXP_SIGNED;
                    v_go    = 1'b1;
                end else if (is_dig) begin
                    n_phase = PH_EXP_DIG;
                    v_go    = 1'b1;
                end else begin
                    v_bad = 1'b1;
                end
            end
            PH_EXP_SIGNED: begin
                if (is_dig) begin
                    n_phase = PH_EXP_DIG;
                    v_go    = 1'b1;
                end else begin
                    v_bad = 1'b1;
                end
            end
            PH_EXP_DIG: begin
                if (is_dig) begin
                    v_go = 1'b1;
                end else begin
                    v_after = 1'b1;
                end
            end
            PH_DEN0: begin
                if (is_rdig) begin
                    n_phase = PH_DEN;
                    v_go    = 1'b1;
                end else begin
                    v_bad = 1'b1;
                end
            end
            PH_DEN: begin
                if (is_rdig) begin
                    v_go = 1'b1;
                end else begin
                    v_after = 1'b1;
                end
            end
            PH_TAIL: begin
                v_bad = !is_del;
            end
            default: begin
                v_bad = 1'b1;
            end
        endcase

        // end of a part: decide between finishing, a second part, the trailing i or an error
        if (v_after) begin
            if (r_form == FORM_REAL) begin
                if (is_del) begin
                    if (n_cur.kind == K_BARE_I) begin
                        v_move = 1'b1;
                        n_form = FORM_RECT;
                    end
                end else if (n_cur.kind == K_BARE_I) begin
                    v_bad = 1'b1;
                end else if (lo == "i") begin
                    if (n_cur.sign == SIGN_NONE) begin
                        v_bad = 1'b1;
                    end else begin
                        v_move  = 1'b1;
                        n_form  = FORM_RECT;
                        n_phase = PH_TAIL;
                        v_go    = 1'b1;
                    end
                end else if (ch == "@") begin
                    n_form   = FORM_POLAR;
                    n_digits = 3'd0;
                    n_phase  = PH_PART_BEGIN;
                    v_go     = 1'b1;
                end else if (is_sign) begin
                    n_form   = FORM_RECT;
                    n_digits = 3'd0;
                    v_sign2  = 1'b1;
                    n_phase  = PH_AFTER_SIGN;
                    v_go     = 1'b1;
                end else begin
                    v_bad = 1'b1;
                end
            end else if (r_form == FORM_POLAR || n_cur.kind == K_BARE_I) begin
                v_bad = !(is_del && !(r_form == FORM_POLAR && n_cur.kind == K_BARE_I));
            end else if (chv && lo == "i") begin
                n_phase = PH_TAIL;
                v_go    = 1'b1;
            end else begin
                v_bad = 1'b1;
            end
        end

        if (r_form != FORM_REAL) begin
            n_first  = r_first;
            n_second = n_cur;
        end else begin
            n_first  = n_cur;
            n_second = r_second;
        end
        if (v_move) begin
            n_second = n_first;
            n_first  = '0;
        end
        if (v_sign2) begin
            n_second.sign = sign_code;
        end

        // decode error wins; length limit applies to every consumed character
        if (i_in_data.bad_sequence) begin
            v_go  = 1'b0;
            v_bad = 1'b0;
        end else if (v_go) begin
            if (32'(r_token_count) >= MAX_TOKEN_LEN) begin
                v_go  = 1'b0;
                v_bad = 1'b1;
            end else if (r_token_count != 8'hFF) begin
                n_token_count = r_token_count + 8'd1;
            end
        end

        res_valid        = !v_go;
        res              = '0;
        res.token_length = r_token_count;
        if (i_in_data.bad_sequence) begin
            res.status = STATUS_DECODE;
        end else if (v_bad) begin
            res.status = STATUS_INVALID;
        end else begin
            res.status          = STATUS_OK;
            res.radix_code      = n_radix;
            res.exactness       = n_exact;
            res.form            = n_form;
            res.first_kind      = n_first.kind;
            res.first_sign      = n_first.sign;
            res.first_exponent  = n_first.expo;
            res.second_kind     = n_second.kind;
            res.second_sign     = n_second.sign;
            res.second_exponent = n_second.expo;
        end
    end

    // parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && res_valid)) begin
            r_phase       <= PH_PREFIX;
            r_radix       <= RADIX_DEC;
            r_flags       <= 2'b00;
            r_exact       <= EXACT_NONE;
            r_form        <= FORM_REAL;
            r_first       <= '0;
            r_second      <= '0;
            r_digits      <= 3'd0;
            r_token_count <= 8'd0;
        end else if (accept) begin
            r_phase       <= n_phase;
            r_radix       <= n_radix;
            r_flags       <= n_flags;
            r_exact       <= n_exact;
            r_form        <= n_form;
            r_first       <= n_first;
            r_second      <= n_second;
            r_digits      <= n_digits;
            r_token_count <= n_token_count;
        end
    end

    // result register with one skid entry behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (take || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= accept && res_valid;
            end
        end else if (accept && res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (accept && res_valid) begin
                r_out <= res;
            end
        end else if (accept && res_valid) begin
            r_skid <= res;
        end
    end

endmodule

// ----- hdl/snl_checker.sv -----
// port-level checks for the number literal lexer, bound to the top level
`include "scheme_number_literal_lexer_defines.svh"

module snl_checker
    import snl_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out_data
);

    logic fail_clear;
    logic ok_shape;

    assign fail_clear = {o_out_data.radix_code, o_out_data.exactness, o_out_data.form,
                         o_out_data.first_kind, o_out_data.first_sign,
                         o_out_data.first_exponent, o_out_data.second_kind,
                         o_out_data.second_sign, o_out_data.second_exponent} == '0;

    assign ok_shape = o_out_data.token_length != 8'd0 &&
                      (o_out_data.form != FORM_REAL || o_out_data.second_kind == K_NONE);

    // a held result beat keeps its payload
    `SNL_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data))

    // input side only stalls when a result is waiting
    `SNL_ASSERT_IMPL(a_stall_needs_result, !o_in_ready, o_out_valid)

    // failed literal carries only its status and token length
    `SNL_ASSERT_IMPL(a_fail_zero, o_out_valid && o_out_data.status != STATUS_OK, fail_clear)

    // success needs at least one character and a real form has no second part
    `SNL_ASSERT_IMPL(a_ok_shape, o_out_valid && o_out_data.status == STATUS_OK, ok_shape)

endmodule

bind scheme_number_literal_lexer snl_checker u_snl_checker (.*);
